/* rtl/core/pmms_pkg.sv */
// ----------------------------------------------------------------------------
// pmms_pkg
// Shared types and constants for the plane min/max/sum/SAD statistics block.
// ----------------------------------------------------------------------------
package pmms_pkg;

  localparam int LANES      = 4;
  localparam int SAMPLE_W   = 16;
  localparam int LANE_CNT_W = 3;
  localparam int GROUP_W    = SAMPLE_W + $clog2(LANES);
  localparam int OUT_SUM_W  = 48;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DEPTH   = 1'd1;

  localparam logic [CFG_DATA_W-1:0] DEPTH_MIN = 5'd8;
  localparam logic [CFG_DATA_W-1:0] DEPTH_MAX = 5'd16;
  localparam logic [SAMPLE_W-1:0]   MASK_RESET = 16'h00FF;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   sample_a0;
    logic [SAMPLE_W-1:0]   sample_a1;
    logic [SAMPLE_W-1:0]   sample_a2;
    logic [SAMPLE_W-1:0]   sample_a3;
    logic [SAMPLE_W-1:0]   sample_b0;
    logic [SAMPLE_W-1:0]   sample_b1;
    logic [SAMPLE_W-1:0]   sample_b2;
    logic [SAMPLE_W-1:0]   sample_b3;
    logic [LANE_CNT_W-1:0] valid_lanes;
    logic                  last_of_frame;
  } sample_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  frame_min;
    logic [SAMPLE_W-1:0]  frame_max;
    logic [OUT_SUM_W-1:0] frame_sum;
    logic [OUT_SUM_W-1:0] frame_diff_sum;
    logic                 overflow;
  } result_item_t;

  // live configuration
  typedef struct packed {
    logic                compare_enable;
    logic [SAMPLE_W-1:0] sample_mask;
  } cfg_t;

  // per-group reduction handed to the accumulator stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] gmin;
    logic [SAMPLE_W-1:0] gmax;
    logic [GROUP_W-1:0]  gsum;
    logic [GROUP_W-1:0]  gdiff;
    logic                last;
  } group_t;

endpackage

/* rtl/core/pmms_cfg.sv */
// ----------------------------------------------------------------------------
// pmms_cfg
// Configuration registers; sample depth is clamped and kept as a sample bit mask.
// ----------------------------------------------------------------------------
module pmms_cfg
  import pmms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic                  compare_enable;
  logic [SAMPLE_W-1:0]   sample_mask;
  logic [SAMPLE_W-1:0]   sample_mask_next;
  logic [CFG_DATA_W-1:0] depth;

  always_comb begin
    depth = cfg_data;
    if (depth < DEPTH_MIN) depth = DEPTH_MIN;
    if (depth > DEPTH_MAX) depth = DEPTH_MAX;
    sample_mask_next = SAMPLE_W'(((SAMPLE_W+1)'(1) << depth) - (SAMPLE_W+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_enable <= 1'b0;
      sample_mask    <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMPARE_ENABLE: compare_enable <= cfg_data[0];
        REG_SAMPLE_DEPTH:   sample_mask    <= sample_mask_next;
        default: ;
      endcase
    end
  end

  assign cfg.compare_enable = compare_enable;
  assign cfg.sample_mask    = sample_mask;

endmodule

/* rtl/core/pmms_lanes.sv */
// ----------------------------------------------------------------------------
// pmms_lanes
// Masks the lanes of one group, reduces them to min/max/sum/SAD and
// registers the result as the input stage.
// ----------------------------------------------------------------------------
module pmms_lanes
  import pmms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         sample_valid,
  output logic         sample_ready,
  input  sample_item_t sample_data,
  output logic         grp_valid,
  input  logic         grp_take,
  output group_t       grp
);

  logic [SAMPLE_W-1:0]   lane_a [LANES];
  logic [SAMPLE_W-1:0]   lane_b [LANES];
  logic [LANE_CNT_W-1:0] lane_count;
  group_t                grp_next;

  assign lane_a[0] = sample_data.sample_a0;
  assign lane_a[1] = sample_data.sample_a1;
  assign lane_a[2] = sample_data.sample_a2;
  assign lane_a[3] = sample_data.sample_a3;
  assign lane_b[0] = sample_data.sample_b0;
  assign lane_b[1] = sample_data.sample_b1;
  assign lane_b[2] = sample_data.sample_b2;
  assign lane_b[3] = sample_data.sample_b3;

  assign lane_count = (sample_data.valid_lanes > LANE_CNT_W'(LANES)) ?
                      LANE_CNT_W'(LANES) : sample_data.valid_lanes;

  always_comb begin
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] d;
    grp_next      = '0;
    grp_next.gmin = '1;
    grp_next.last = sample_data.last_of_frame;
    for (int i = 0; i < LANES; i++) begin
      a = lane_a[i] & cfg.sample_mask;
      b = lane_b[i] & cfg.sample_mask;
      d = (a > b) ? (a - b) : (b - a);
      if (LANE_CNT_W'(i) < lane_count) begin
        if (a < grp_next.gmin) grp_next.gmin = a;
        if (a > grp_next.gmax) grp_next.gmax = a;
        grp_next.gsum  = grp_next.gsum + GROUP_W'(a);
        grp_next.gdiff = grp_next.gdiff + GROUP_W'(d);
      end
    end
  end

  assign sample_ready = !grp_valid || grp_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (sample_ready) begin
      grp_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      grp <= grp_next;
    end
  end

  // stage must hold a group until the accumulator takes it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp_take |=> grp_valid && $stable(grp))
    else $error("input stage dropped or changed a pending group");

  a_load: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> grp_valid)
    else $error("accepted transaction did not reach the input stage");

endmodule

/* rtl/core/pmms_accum.sv */
// ----------------------------------------------------------------------------
// pmms_accum
// Frame accumulators with saturation, and the result register.
// ----------------------------------------------------------------------------
module pmms_accum
  import pmms_pkg::*;
#(
  parameter int ACC_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         grp_valid,
  output logic         grp_take,
  input  group_t       grp,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_data
);

  logic [SAMPLE_W-1:0]  run_min;
  logic [SAMPLE_W-1:0]  run_max;
  logic [ACC_WIDTH-1:0] run_sum;
  logic [ACC_WIDTH-1:0] run_diff;
  logic                 run_ovf;

  logic [SAMPLE_W-1:0]  run_min_next;
  logic [SAMPLE_W-1:0]  run_max_next;
  logic [ACC_WIDTH-1:0] run_sum_next;
  logic [ACC_WIDTH-1:0] run_diff_next;
  logic                 run_ovf_next;
  logic [ACC_WIDTH:0]   sum_ext;
  logic [ACC_WIDTH:0]   diff_ext;
  logic                 sum_sat;
  logic                 diff_sat;
  result_item_t         result_next;

  // a last group needs a free result slot; other groups always go
  assign grp_take = grp_valid && (!grp.last || !result_valid || result_ready);

  always_comb begin
    sum_ext  = {1'b0, run_sum} + (ACC_WIDTH+1)'(grp.gsum);
    diff_ext = {1'b0, run_diff} + (ACC_WIDTH+1)'(grp.gdiff);
    sum_sat  = sum_ext[ACC_WIDTH];
    diff_sat = cfg.compare_enable && diff_ext[ACC_WIDTH];

    run_min_next = (grp.gmin < run_min) ? grp.gmin : run_min;
    run_max_next = (grp.gmax > run_max) ? grp.gmax : run_max;
    run_sum_next = sum_sat ? '1 : sum_ext[ACC_WIDTH-1:0];
    if (!cfg.compare_enable) begin
      run_diff_next = run_diff;
    end else if (diff_sat) begin
      run_diff_next = '1;
    end else begin
      run_diff_next = diff_ext[ACC_WIDTH-1:0];
    end
    run_ovf_next = run_ovf || sum_sat || diff_sat;

    result_next.frame_min = (run_min_next < cfg.sample_mask) ? run_min_next : cfg.sample_mask;
    result_next.frame_max = run_max_next;
    result_next.frame_sum = OUT_SUM_W'(run_sum_next);
    result_next.frame_diff_sum = cfg.compare_enable ? OUT_SUM_W'(run_diff_next) : '0;
    result_next.overflow = run_ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= '1;
      run_max <= '0;
      run_sum <= '0;
      run_diff <= '0;
      run_ovf <= 1'b0;
    end else if (grp_take) begin
      if (grp.last) begin
        run_min <= '1;
        run_max <= '0;
        run_sum <= '0;
        run_diff <= '0;
        run_ovf <= 1'b0;
      end else begin
        run_min <= run_min_next;
        run_max <= run_max_next;
        run_sum <= run_sum_next;
        run_diff <= run_diff_next;
        run_ovf <= run_ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (grp_take && grp.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take && grp.last) begin
      result_data <= result_next;
    end
  end

  a_emit: assert property (@(posedge clk) disable iff (rst)
    grp_take && grp.last |=> result_valid)
    else $error("last group did not raise a result");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    grp_take && grp.last |=> run_sum == '0 && run_diff == '0 && !run_ovf && run_min == '1)
    else $error("frame state not cleared after last group");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("pending result overwritten");

endmodule

/* rtl/core/plane_min_max_sum_sad.sv */
// ----------------------------------------------------------------------------
// plane_min_max_sum_sad
// Frame statistics over plane A (min, max, saturating sum) plus the
// saturating sum of |A - B| against plane B (zero unless compare is on),
// reported once per frame.
// Throughput: one group of LANES samples per clock, except while a last group
// waits. A last group passes the input register, then loads the result register.
// Stall: only a last group waits, when the result register still holds an
// untaken result; other groups flow on regardless of result_ready.
// Reset: synchronous; clears both pipeline valids, the frame accumulators
// and the registers (compare off, sample depth 8).
// ----------------------------------------------------------------------------
module plane_min_max_sum_sad
  import pmms_pkg::*;
#(
  parameter int ACC_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes; the user must write only while idle (not enforced)
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // sample groups
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_item_t           sample_data,
  // frame results
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_item_t           result_data
);

  cfg_t   cfg;
  logic   grp_valid;
  logic   grp_take;
  group_t grp;

  // Register file: compare enable and the clamped depth, kept as a mask so
  // the lane logic only ANDs it in.
  pmms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage 1: per-lane mask and 4-lane reduction into the input register.
  // sample_ready only depends on whether the accumulator drains this stage,
  // so a waiting result does not block ordinary groups.
  pmms_lanes u_lanes (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .grp_valid    (grp_valid),
    .grp_take     (grp_take),
    .grp          (grp)
  );

  // Stage 2: one wide saturating add per sum, running min/max, and the
  // result register loaded on the last group of a frame.
  pmms_accum #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .grp_valid    (grp_valid),
    .grp_take     (grp_take),
    .grp          (grp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  // a group in stage 1 that is not the frame end never waits
  a_flow: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp.last |-> grp_take)
    else $error("non-final group stalled in stage 1");

endmodule
